@@ sv/nearest_palette_color_search_defines.svh @@
// assertion macros for the nearest palette color search block
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define NPCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("npcs: invariant violated");
`define NPCS_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npcs: same-cycle implication violated");
`define NPCS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npcs: next-cycle implication violated");
`else
`define NPCS_ASSERT(lbl, prop)
`define NPCS_IMPLIES(lbl, ante, cons)
`define NPCS_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/npcs_pkg.sv @@
package npcs_pkg;

    typedef logic [1:0]  req_type_t;
    typedef logic [1:0]  status_t;
    typedef logic [7:0]  chan_t;
    // packed as {blue, green, red}
    typedef logic [23:0] color_t;

    localparam req_type_t REQ_CLEAR  = 2'd0;
    localparam req_type_t REQ_APPEND = 2'd1;
    localparam req_type_t REQ_QUERY  = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // redmean weights, red gets base + avg, blue gets base - avg
    localparam logic [9:0] RED_WEIGHT_BASE  = 10'd512;
    localparam logic [9:0] BLUE_WEIGHT_BASE = 10'd767;

    localparam int MUL_A_W = 10;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // largest distance sum stays below 2^20
    localparam int SUM_W   = 20;

endpackage

@@ sv/npcs_req_if.sv @@
interface npcs_req_if;
    import npcs_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    chan_t     red_in;
    chan_t     green_in;
    chan_t     blue_in;

    modport source (output valid, output req_type, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input req_type, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

@@ sv/npcs_rsp_if.sv @@
interface npcs_rsp_if;
    import npcs_pkg::*;

    logic    valid;
    logic    ready;
    chan_t   entry_index;
    chan_t   red_out;
    chan_t   green_out;
    chan_t   blue_out;
    status_t status;

    modport source (output valid, output entry_index, output red_out, output green_out,
                    output blue_out, output status, input ready);
    modport sink   (input valid, input entry_index, input red_out, input green_out,
                    input blue_out, input status, output ready);
endinterface

@@ sv/nearest_palette_color_search.sv @@
// nearest palette color search
// req channel: one word per request, req_type selects clear, append or query,
// red_in/green_in/blue_in carry the color. rsp channel: exactly one word per
// request with entry_index, the chosen color and status.
// clear, append and a query on an empty palette pass from acceptance through S_FIN
// into the output register, which raises rsp.valid. a query reads the palette
// memory one entry at a time and runs one shared 10x16 multiplier five times per
// entry between the read, difference and compare steps, and an exact match stops
// the walk early. req.ready is high only while no request is in work, so requests
// do not overlap.
// rsp is held in an output register: a finished word waits there while
// rsp.ready is low, and the next request is still accepted meanwhile; it
// finishes but stays internal until the output register frees up.
// reset empties the palette (entry count zero) and drops any pending word;
// no clearing pass runs, since entries at or above the count are never read.
`include "nearest_palette_color_search_defines.svh"

module nearest_palette_color_search #(
    parameter int MAX_COLORS = 256
) (
    input logic        clk,
    input logic        rst_n,
    npcs_req_if.sink   req,
    npcs_rsp_if.source rsp
);
    import npcs_pkg::*;

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int CNT_W = $clog2(MAX_COLORS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_QUERY = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    localparam logic [2:0] PH_READ  = 3'd0;
    localparam logic [2:0] PH_DIFF  = 3'd1;
    localparam logic [2:0] PH_SQR_R = 3'd2;
    localparam logic [2:0] PH_WGT_R = 3'd3;
    localparam logic [2:0] PH_SQR_G = 3'd4;
    localparam logic [2:0] PH_SQR_B = 3'd5;
    localparam logic [2:0] PH_WGT_B = 3'd6;
    localparam logic [2:0] PH_CMP   = 3'd7;

    color_t palette_mem [MAX_COLORS];

    logic [1:0]         state_reg, state_next;
    logic [2:0]         ph_reg, ph_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic               out_valid_reg, out_valid_next;

    color_t             qcolor_reg, qcolor_next;
    color_t             rd_reg;
    chan_t              dr_reg, dr_next;
    chan_t              dg_reg, dg_next;
    chan_t              db_reg, db_next;
    chan_t              ravg_reg, ravg_next;
    logic [MUL_P_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   best_reg, best_next;
    chan_t              res_idx_reg, res_idx_next;
    color_t             res_color_reg, res_color_next;
    status_t            res_status_reg, res_status_next;
    chan_t              out_idx_reg, out_idx_next;
    color_t             out_color_reg, out_color_next;
    status_t            out_status_reg, out_status_next;

    logic               mem_we;
    logic               mem_re;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [SUM_W-1:0]   dist_sum;
    logic [8:0]         rsum;
    logic               req_acc;
    logic               last_entry;
    logic               out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_index = out_idx_reg;
    assign rsp.red_out     = out_color_reg[7:0];
    assign rsp.green_out   = out_color_reg[15:8];
    assign rsp.blue_out    = out_color_reg[23:16];
    assign rsp.status      = out_status_reg;

    assign rsum       = {1'b0, qcolor_reg[7:0]} + {1'b0, rd_reg[7:0]};
    assign last_entry = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign dist_sum   = sum_reg + SUM_W'(prod_reg[MUL_P_W-1:8]);

    // the shared multiplier, operands picked by phase
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ph_reg)
            PH_SQR_R:
            begin
                mul_a = MUL_A_W'(dr_reg);
                mul_b = MUL_B_W'(dr_reg);
            end
            PH_WGT_R:
            begin
                mul_a = RED_WEIGHT_BASE + MUL_A_W'(ravg_reg);
                mul_b = prod_reg[MUL_B_W-1:0];
            end
            PH_SQR_G:
            begin
                mul_a = MUL_A_W'(dg_reg);
                mul_b = MUL_B_W'(dg_reg);
            end
            PH_SQR_B:
            begin
                mul_a = MUL_A_W'(db_reg);
                mul_b = MUL_B_W'(db_reg);
            end
            PH_WGT_B:
            begin
                mul_a = BLUE_WEIGHT_BASE - MUL_A_W'(ravg_reg);
                mul_b = prod_reg[MUL_B_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        out_valid_next  = out_valid_reg;
        qcolor_next     = qcolor_reg;
        dr_next         = dr_reg;
        dg_next         = dg_reg;
        db_next         = db_reg;
        ravg_next       = ravg_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        best_next       = best_reg;
        res_idx_next    = res_idx_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        out_idx_next    = out_idx_reg;
        out_color_next  = out_color_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    qcolor_next     = {req.blue_in, req.green_in, req.red_in};
                    res_idx_next    = '0;
                    res_color_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_FIN;
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_COLORS))
                            begin
                                mem_we       = 1'b1;
                                res_idx_next = 8'(count_reg);
                                count_next   = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_idx_next    = 8'(MAX_COLORS - 1);
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                ph_next    = PH_READ;
                                state_next = S_QUERY;
                            end
                        end
                        default:
                        begin
                            // unused request code, answered with an all-zero word
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_QUERY:
            begin
                unique case (ph_reg)
                    PH_READ:
                    begin
                        mem_re  = 1'b1;
                        ph_next = PH_DIFF;
                    end
                    PH_DIFF:
                    begin
                        if (rd_reg == qcolor_reg)
                        begin
                            // exact match ends the walk
                            res_idx_next   = 8'(i_reg);
                            res_color_next = rd_reg;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            dr_next   = (qcolor_reg[7:0] > rd_reg[7:0])
                                      ? qcolor_reg[7:0] - rd_reg[7:0]
                                      : rd_reg[7:0] - qcolor_reg[7:0];
                            dg_next   = (qcolor_reg[15:8] > rd_reg[15:8])
                                      ? qcolor_reg[15:8] - rd_reg[15:8]
                                      : rd_reg[15:8] - qcolor_reg[15:8];
                            db_next   = (qcolor_reg[23:16] > rd_reg[23:16])
                                      ? qcolor_reg[23:16] - rd_reg[23:16]
                                      : rd_reg[23:16] - qcolor_reg[23:16];
                            ravg_next = rsum[8:1];
                            ph_next   = PH_SQR_R;
                        end
                    end
                    PH_SQR_R:
                    begin
                        prod_next = mul_p;
                        ph_next   = PH_WGT_R;
                    end
                    PH_WGT_R:
                    begin
                        prod_next = mul_p;
                        ph_next   = PH_SQR_G;
                    end
                    PH_SQR_G:
                    begin
                        sum_next  = SUM_W'(prod_reg[MUL_P_W-1:8]);
                        prod_next = mul_p;
                        ph_next   = PH_SQR_B;
                    end
                    PH_SQR_B:
                    begin
                        sum_next  = sum_reg + SUM_W'({prod_reg[MUL_B_W-1:0], 2'b00});
                        prod_next = mul_p;
                        ph_next   = PH_WGT_B;
                    end
                    PH_WGT_B:
                    begin
                        prod_next = mul_p;
                        ph_next   = PH_CMP;
                    end
                    PH_CMP:
                    begin
                        // first entry always taken, later ones only on a strict win
                        if (i_reg == '0 || dist_sum < best_reg)
                        begin
                            best_next      = dist_sum;
                            res_idx_next   = 8'(i_reg);
                            res_color_next = rd_reg;
                        end
                        if (last_entry)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            i_next  = i_reg + IDX_W'(1);
                            ph_next = PH_READ;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_READ;
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = res_idx_reg;
                    out_color_next  = res_color_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_READ;
            count_reg     <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qcolor_reg     <= qcolor_next;
        dr_reg         <= dr_next;
        dg_reg         <= dg_next;
        db_reg         <= db_next;
        ravg_reg       <= ravg_next;
        prod_reg       <= prod_next;
        sum_reg        <= sum_next;
        best_reg       <= best_next;
        res_idx_reg    <= res_idx_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        out_idx_reg    <= out_idx_next;
        out_color_reg  <= out_color_next;
        out_status_reg <= out_status_next;
    end

    // palette memory, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[count_reg[IDX_W-1:0]] <= {req.blue_in, req.green_in, req.red_in};
        end
        if (mem_re)
        begin
            rd_reg <= palette_mem[i_reg];
        end
    end

    `NPCS_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_COLORS))
    `NPCS_IMPLIES(a_walk_in_range, state_reg == S_QUERY, CNT_W'(i_reg) < count_reg)
    `NPCS_IMPLIES(a_empty_only_when_empty, state_reg == S_FIN && res_status_reg == ST_EMPTY, count_reg == '0)
    `NPCS_NEXT(a_append_grows, req_acc && req.req_type == REQ_APPEND && count_reg < CNT_W'(MAX_COLORS), count_reg == $past(count_reg) + CNT_W'(1))

endmodule

@@ tb/sv/tb_nearest_palette_color_search.sv @@
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    localparam int MAX_COLORS   = 256;
    localparam int TOTAL_ITEMS  = 900;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        chan_t   entry_index;
        chan_t   red;
        chan_t   green;
        chan_t   blue;
        status_t status;
    } match_word_t;

    typedef struct {
        req_type_t   kind;
        color_t      color;
        bit          typed;
        match_word_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    npcs_req_if req_if ();
    npcs_rsp_if rsp_if ();

    nearest_palette_color_search #(
        .MAX_COLORS (MAX_COLORS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // palette as the block should hold it
    color_t      pal_colors [MAX_COLORS];
    int unsigned pal_count;

    match_word_t expected_words [$];
    stim_row_t   directed_rows [$];
    int          mismatches;
    int          burst_left;
    int          items_sent;
    int          idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic color_t rgb(chan_t r, chan_t g, chan_t b);
        return {b, g, r};
    endfunction

    function automatic match_word_t make_word(chan_t idx, color_t c, status_t st);
        match_word_t w;
        w.entry_index = idx;
        w.red         = c[7:0];
        w.green       = c[15:8];
        w.blue        = c[23:16];
        w.status      = st;
        return w;
    endfunction

    function automatic void add_row(req_type_t kind, color_t c, bit typed, match_word_t want);
        stim_row_t row;
        row.kind  = kind;
        row.color = c;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic int unsigned absdiff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // redmean distance without the square root
    function automatic int unsigned redmean_sum(color_t q, color_t e);
        int unsigned qr;
        int unsigned er;
        int unsigned ravg;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        qr   = q[7:0];
        er   = e[7:0];
        ravg = (qr + er) >> 1;
        dr   = absdiff(qr, er);
        dg   = absdiff(int'(q[15:8]), int'(e[15:8]));
        db   = absdiff(int'(q[23:16]), int'(e[23:16]));
        return (((int'(RED_WEIGHT_BASE) + ravg) * dr * dr) >> 8)
             + 4 * dg * dg
             + (((int'(BLUE_WEIGHT_BASE) - ravg) * db * db) >> 8);
    endfunction

    // advances the palette copy by one accepted request
    function automatic match_word_t predict_match(req_type_t kind, color_t c);
        match_word_t w;
        int unsigned best;
        int unsigned d;
        int unsigned pick;
        w = '0;
        case (kind)
            REQ_CLEAR:
            begin
                pal_count = 0;
            end
            REQ_APPEND:
            begin
                if (pal_count >= MAX_COLORS)
                begin
                    w.status = ST_FULL;
                end
                else
                begin
                    w.entry_index         = pal_count[7:0];
                    pal_colors[pal_count] = c;
                    pal_count++;
                end
            end
            REQ_QUERY:
            begin
                if (pal_count == 0)
                begin
                    w = make_word(chan_t'(MAX_COLORS - 1), '0, ST_EMPTY);
                end
                else
                begin
                    best = 0;
                    pick = 0;
                    for (int i = 0; i < int'(pal_count); i++)
                    begin
                        // exact color stops the walk
                        if (pal_colors[i] == c)
                        begin
                            pick = i;
                            break;
                        end
                        d = redmean_sum(c, pal_colors[i]);
                        if (i == 0 || d < best)
                        begin
                            best = d;
                            pick = i;
                        end
                    end
                    w = make_word(pick[7:0], pal_colors[pick], ST_OK);
                end
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    function automatic chan_t pick_chan();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic chan_t near_chan(chan_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return chan_t'(v);
    endfunction

    function automatic color_t random_color();
        return rgb(pick_chan(), pick_chan(), pick_chan());
    endfunction

    // exact copies and near neighbors of stored entries give ties and early stops
    function automatic color_t probe_color();
        color_t e;
        if (pal_count == 0)
            return random_color();
        e = pal_colors[$urandom_range(0, pal_count - 1)];
        case ($urandom_range(0, 3))
            0:       return e;
            1:       return rgb(near_chan(e[7:0]), near_chan(e[15:8]), near_chan(e[23:16]));
            default: return random_color();
        endcase
    endfunction

    function automatic color_t palette_color();
        if (pal_count != 0 && $urandom_range(0, 3) == 0)
            return probe_color();
        return random_color();
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    task automatic send_word(req_type_t kind, color_t c, bit typed, match_word_t want);
        match_word_t pred;
        int          gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.red_in   <= c[7:0];
        req_if.green_in <= c[15:8];
        req_if.blue_in  <= c[23:16];
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        pred = predict_match(kind, c);
        expected_words.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // response side stalls in modes picked at random: always ready, coin flip, mostly low or periodic
    initial
    begin
        int mode;
        int hold;
        int tick;
        rsp_if.ready = 1'b0;
        mode = 0;
        hold = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(20, 200);
            end
            hold--;
            tick++;
            case (mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                2:       rsp_if.ready <= ($urandom_range(0, 4) == 0);
                default: rsp_if.ready <= ((tick % 9) >= 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        match_word_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("word with none pending", rsp_if.entry_index, 0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_if.entry_index !== want.entry_index)
                    report_mismatch("entry_index", rsp_if.entry_index, want.entry_index);
                if (rsp_if.red_out !== want.red)
                    report_mismatch("red_out", rsp_if.red_out, want.red);
                if (rsp_if.green_out !== want.green)
                    report_mismatch("green_out", rsp_if.green_out, want.green);
                if (rsp_if.blue_out !== want.blue)
                    report_mismatch("blue_out", rsp_if.blue_out, want.blue);
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
            end
        end
    end

    // a full-palette query is the longest legal quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        int m;
        int fills_done;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_CLEAR;
        req_if.red_in   = '0;
        req_if.green_in = '0;
        req_if.blue_in  = '0;
        mismatches      = 0;
        burst_left      = 0;
        items_sent      = 0;
        pal_count       = 0;
        fills_done      = 0;

        // empty after reset, single entry, clear hides old entries
        add_row(REQ_QUERY,  rgb(10, 20, 30),    1, make_word(8'd255, '0, ST_EMPTY));
        add_row(REQ_APPEND, rgb(0, 0, 0),       1, make_word(8'd0, '0, ST_OK));
        add_row(REQ_QUERY,  rgb(255, 255, 255), 1, make_word(8'd0, rgb(0, 0, 0), ST_OK));
        add_row(REQ_CLEAR,  rgb(255, 255, 255), 1, '0);
        add_row(REQ_QUERY,  rgb(0, 0, 0),       1, make_word(8'd255, '0, ST_EMPTY));
        // primaries plus a repeated red for the first-minimum rule
        add_row(REQ_APPEND, rgb(255, 255, 255), 1, make_word(8'd0, '0, ST_OK));
        add_row(REQ_APPEND, rgb(255, 0, 0),     1, make_word(8'd1, '0, ST_OK));
        add_row(REQ_APPEND, rgb(0, 255, 0),     1, make_word(8'd2, '0, ST_OK));
        add_row(REQ_APPEND, rgb(0, 0, 255),     1, make_word(8'd3, '0, ST_OK));
        add_row(REQ_APPEND, rgb(0, 0, 0),       1, make_word(8'd4, '0, ST_OK));
        add_row(REQ_APPEND, rgb(255, 0, 0),     1, make_word(8'd5, '0, ST_OK));
        add_row(REQ_QUERY,  rgb(255, 0, 0),     1, make_word(8'd1, rgb(255, 0, 0), ST_OK));
        add_row(REQ_QUERY,  rgb(0, 0, 0),       1, make_word(8'd4, rgb(0, 0, 0), ST_OK));
        add_row(REQ_QUERY,  rgb(250, 5, 5),     0, '0);
        add_row(REQ_QUERY,  rgb(128, 128, 128), 0, '0);
        add_row(REQ_QUERY,  rgb(0, 0, 1),       0, '0);
        add_row(REQ_QUERY,  rgb(255, 255, 254), 0, '0);
        add_row(REQ_QUERY,  rgb(1, 254, 1),     0, '0);
        add_row(REQ_APPEND, rgb(170, 85, 51),   0, '0);
        add_row(REQ_QUERY,  rgb(85, 170, 204),  0, '0);
        add_row(REQ_CLEAR,  rgb(0, 0, 0),       1, '0);
        add_row(REQ_APPEND, rgb(1, 2, 3),       1, make_word(8'd0, '0, ST_OK));
        add_row(REQ_QUERY,  rgb(200, 100, 50),  1, make_word(8'd0, rgb(1, 2, 3), ST_OK));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].kind, directed_rows[i].color, directed_rows[i].typed,
                      directed_rows[i].want);

        while (items_sent < TOTAL_ITEMS)
        begin
            if ((fills_done == 0 && items_sent >= 100) || (fills_done == 1 && items_sent >= 550))
            begin
                // fill to the top, append past it, query the full palette
                send_word(REQ_CLEAR, random_color(), 0, '0);
                while (pal_count < MAX_COLORS)
                    send_word(REQ_APPEND, palette_color(), 0, '0);
                repeat (2) send_word(REQ_APPEND, random_color(), 0, '0);
                send_word(REQ_QUERY, pal_colors[MAX_COLORS - 1], 0, '0);
                repeat (3) send_word(REQ_QUERY, probe_color(), 0, '0);
                send_word(REQ_CLEAR, random_color(), 0, '0);
                fills_done++;
            end
            else
            begin
                if ($urandom_range(0, 9) < 8)
                    send_word(REQ_CLEAR, random_color(), 0, '0);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
                repeat (n) send_word(REQ_APPEND, palette_color(), 0, '0);
                m = $urandom_range(1, 6);
                repeat (m) send_word(REQ_QUERY, probe_color(), 0, '0);
            end
        end
        req_if.valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
